// ===== rtl/infix_expression_evaluator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the infix expression evaluator
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication
`define IEE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IEE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// Shared constants, codes, payload types and control structs of the
// infix expression evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iee_pkg;

  // Sizing
  localparam int STACK_DEPTH  = 8;
  localparam int VALUE_WIDTH  = 16;
  localparam int TARGET_WIDTH = 16;
  localparam int IDX_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W    = $clog2(VALUE_WIDTH + 1);
  localparam int CMP_W        = (VALUE_WIDTH > TARGET_WIDTH) ? VALUE_WIDTH : TARGET_WIDTH;

  localparam logic signed [TARGET_WIDTH-1:0] TARGET_RESET = TARGET_WIDTH'(24);

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_TIMES = 8'h78;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK,
    ERR_CHAR,
    ERR_FORM,
    ERR_DIV0,
    ERR_OVF
  } err_e;

  typedef struct packed {
    logic [7:0] token_char;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          matches_target;
    logic [2:0]                    error_code;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             opnd_we;
    logic             opnd_wsel_digit;
    logic [IDX_W-1:0] opnd_waddr;
    logic [3:0]       digit;
    logic [IDX_W-1:0] opnd_raddr;
    logic             load_r;
    logic             load_l;
    logic             optr_we;
    logic [IDX_W-1:0] optr_waddr;
    op_e              push_op;
    logic [IDX_W-1:0] optr_raddr;
    logic             arith_start;
    logic             out_load;
    err_e             out_err;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_e  op_top;
    logic arith_done;
    err_e arith_err;
  } dp_status_t;

  // Multiply and divide bind tighter than add and subtract
  function automatic logic op_high_rank(op_e op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage

// ===== rtl/iee_divider.sv =====
// ----------------------------------------------------------------------------
// iee_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_divider import iee_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o
);

  logic [VALUE_WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   busy_q, done_q;
  logic [VALUE_WIDTH:0]   trial, diff;
  logic                   take;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(VALUE_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo_q <= {quo_q[VALUE_WIDTH-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/iee_datapath.sv =====
// ----------------------------------------------------------------------------
// iee_datapath
// Operand and operator stacks, operand registers, arithmetic unit,
// target register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iee_datapath import iee_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [TARGET_WIDTH-1:0] cfg_wdata_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output out_item_t               out_item_o
);

  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [VALUE_WIDTH-1:0]          opnd_mem [STACK_DEPTH];
  op_e                             optr_mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0]          rdata_q;
  logic signed [VALUE_WIDTH-1:0]   l_q, r_q, res_q;
  logic signed [TARGET_WIDTH-1:0]  target_q;
  err_e                            err_q;
  logic                            done_q, neg_q;
  out_item_t                       out_q;

  logic [VALUE_WIDTH-1:0]          wdata, l_mag, r_mag, quo;
  logic [VALUE_WIDTH:0]            sum, dif;
  logic signed [2*VALUE_WIDTH-1:0] prod;
  logic [VALUE_WIDTH:0]            prod_top;
  logic                            div_start, div_done;
  logic signed [VALUE_WIDTH-1:0]   fin_val;
  logic signed [CMP_W-1:0]         val_ext, tgt_ext;

  // Operand stack memory
  assign wdata = cmd_i.opnd_wsel_digit ? {{(VALUE_WIDTH-4){1'b0}}, cmd_i.digit} : res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.opnd_we) begin
      opnd_mem[cmd_i.opnd_waddr] <= wdata;
    end
    rdata_q <= opnd_mem[cmd_i.opnd_raddr];
  end

  // Operator stack, top read only
  always_ff @(posedge clk_i) begin
    if (cmd_i.optr_we) begin
      optr_mem[cmd_i.optr_waddr] <= cmd_i.push_op;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_r) begin
      r_q <= rdata_q;
    end
    if (cmd_i.load_l) begin
      l_q <= rdata_q;
    end
  end

  // Arithmetic
  assign sum      = {l_q[VALUE_WIDTH-1], l_q} + {r_q[VALUE_WIDTH-1], r_q};
  assign dif      = {l_q[VALUE_WIDTH-1], l_q} - {r_q[VALUE_WIDTH-1], r_q};
  assign prod     = l_q * r_q;
  assign prod_top = prod[2*VALUE_WIDTH-1:VALUE_WIDTH-1];
  assign l_mag    = l_q[VALUE_WIDTH-1] ? -l_q : l_q;
  assign r_mag    = r_q[VALUE_WIDTH-1] ? -r_q : r_q;

  assign div_start = cmd_i.arith_start && (status_o.op_top == OP_DIV) && (r_q != '0)
                     && !((l_q == VAL_MIN) && (&r_q));

  iee_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (l_mag),
    .divisor_i  (r_mag),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      err_q  <= ERR_OK;
      res_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.arith_start) begin
        unique case (status_o.op_top)
          OP_ADD: begin
            res_q  <= sum[VALUE_WIDTH-1:0];
            err_q  <= (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) ? ERR_OVF : ERR_OK;
            done_q <= 1'b1;
          end
          OP_SUB: begin
            res_q  <= dif[VALUE_WIDTH-1:0];
            err_q  <= (dif[VALUE_WIDTH] != dif[VALUE_WIDTH-1]) ? ERR_OVF : ERR_OK;
            done_q <= 1'b1;
          end
          OP_MUL: begin
            res_q  <= prod[VALUE_WIDTH-1:0];
            err_q  <= ((&prod_top) || !(|prod_top)) ? ERR_OK : ERR_OVF;
            done_q <= 1'b1;
          end
          default: begin
            neg_q <= l_q[VALUE_WIDTH-1] ^ r_q[VALUE_WIDTH-1];
            if (r_q == '0) begin
              err_q  <= ERR_DIV0;
              done_q <= 1'b1;
            end else if ((l_q == VAL_MIN) && (&r_q)) begin
              err_q  <= ERR_OVF;
              done_q <= 1'b1;
            end
          end
        endcase
      end else if (div_done) begin
        res_q  <= neg_q ? -quo : quo;
        err_q  <= ERR_OK;
        done_q <= 1'b1;
      end
    end
  end

  // Target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Result register
  assign fin_val = (cmd_i.out_err == ERR_OK) ? rdata_q : '0;
  assign val_ext = CMP_W'(fin_val);
  assign tgt_ext = CMP_W'(target_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.value          <= fin_val;
      out_q.matches_target <= (cmd_i.out_err == ERR_OK) && (val_ext == tgt_ext);
      out_q.error_code     <= cmd_i.out_err;
    end
  end

  assign status_o.op_top     = optr_mem[cmd_i.optr_raddr];
  assign status_o.arith_done = done_q;
  assign status_o.arith_err  = err_q;
  assign out_item_o          = out_q;

endmodule

// ===== rtl/iee_ctrl.sv =====
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer: stack counts, sticky error, parsing checks, reduction steps
// and the item handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "infix_expression_evaluator_assert.svh"

module iee_ctrl import iee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_item_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_OP_LOOP,
    S_RD_R,
    S_RD_L,
    S_LD_L,
    S_EXEC,
    S_WAIT,
    S_FINISH,
    S_LAST_LOOP,
    S_LAST_CHK,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] opnd_q, opnd_d, optr_q, optr_d;
  err_e             sticky_q, sticky_d;
  logic [7:0]       tok_q, tok_d;
  logic             last_q, last_d, ret_last_q, ret_last_d, out_valid_q, out_valid_d;
  op_e              op_q, op_d;

  logic [CNT_W-1:0] opnd_m1, opnd_m2, optr_m1;
  logic [CNT_W:0]   opnd_ext, optr_p1;
  logic [7:0]       tok_off;
  logic             tok_digit, tok_is_op, red_bad, red_go;
  op_e              tok_op;

  assign opnd_m1  = opnd_q - 1'b1;
  assign opnd_m2  = opnd_q - CNT_W'(2);
  assign optr_m1  = optr_q - 1'b1;
  assign opnd_ext = {1'b0, opnd_q};
  assign optr_p1  = {1'b0, optr_q} + (CNT_W+1)'(1);
  assign tok_off  = tok_q - CHAR_ZERO;
  assign tok_digit = (tok_q >= CHAR_ZERO) && (tok_q <= CHAR_NINE);
  assign red_bad  = (optr_q == '0) || (opnd_q < CNT_W'(2));
  // pending operator binds at least as tight as the incoming one
  assign red_go   = (optr_q != '0) &&
                    (op_high_rank(status_i.op_top) || !op_high_rank(op_q));

  // Operator decode
  always_comb begin
    tok_op    = OP_ADD;
    tok_is_op = 1'b1;
    unique case (tok_q)
      CHAR_PLUS:  tok_op = OP_ADD;
      CHAR_MINUS: tok_op = OP_SUB;
      CHAR_TIMES: tok_op = OP_MUL;
      CHAR_SLASH: tok_op = OP_DIV;
      default:    tok_is_op = 1'b0;
    endcase
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    opnd_d      = opnd_q;
    optr_d      = optr_q;
    sticky_d    = sticky_q;
    tok_d       = tok_q;
    last_d      = last_q;
    op_d        = op_q;
    ret_last_d  = ret_last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o            = '0;
    cmd_o.opnd_raddr = (state_q == S_RD_L) ? opnd_m2[IDX_W-1:0] : opnd_m1[IDX_W-1:0];
    cmd_o.optr_raddr = optr_m1[IDX_W-1:0];
    cmd_o.digit      = tok_off[3:0];
    cmd_o.push_op    = op_q;
    cmd_o.out_err    = sticky_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tok_d      = in_item_i.token_char;
          last_d     = in_item_i.is_last;
          ret_last_d = 1'b0;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FINISH;
        if (sticky_q == ERR_OK) begin
          if (tok_digit) begin
            if ((opnd_q != optr_q) || (opnd_q >= CNT_W'(STACK_DEPTH))) begin
              sticky_d = ERR_FORM;
            end else begin
              cmd_o.opnd_we         = 1'b1;
              cmd_o.opnd_wsel_digit = 1'b1;
              cmd_o.opnd_waddr      = opnd_q[IDX_W-1:0];
              opnd_d                = opnd_q + 1'b1;
            end
          end else if (tok_is_op) begin
            op_d = tok_op;
            if (opnd_ext != optr_p1) begin
              sticky_d = ERR_FORM;
            end else begin
              state_d = S_OP_LOOP;
            end
          end else begin
            sticky_d = ERR_CHAR;
          end
        end
      end
      S_OP_LOOP: begin
        if (red_go) begin
          if (red_bad) begin
            sticky_d = ERR_FORM;
            state_d  = S_FINISH;
          end else begin
            state_d = S_RD_R;
          end
        end else begin
          state_d = S_FINISH;
          if (optr_q >= CNT_W'(STACK_DEPTH)) begin
            sticky_d = ERR_FORM;
          end else begin
            cmd_o.optr_we    = 1'b1;
            cmd_o.optr_waddr = optr_q[IDX_W-1:0];
            optr_d           = optr_q + 1'b1;
          end
        end
      end
      S_RD_R: begin
        state_d = S_RD_L;
      end
      S_RD_L: begin
        cmd_o.load_r = 1'b1;
        state_d      = S_LD_L;
      end
      S_LD_L: begin
        cmd_o.load_l = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.arith_start = 1'b1;
        state_d           = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.arith_done) begin
          if (status_i.arith_err != ERR_OK) begin
            sticky_d = status_i.arith_err;
            state_d  = S_FINISH;
          end else begin
            // pop two operands and one operator, push the outcome
            cmd_o.opnd_we    = 1'b1;
            cmd_o.opnd_waddr = opnd_m2[IDX_W-1:0];
            opnd_d           = opnd_m1;
            optr_d           = optr_m1;
            state_d          = ret_last_q ? S_LAST_LOOP : S_OP_LOOP;
          end
        end
      end
      S_FINISH: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          if ((sticky_q == ERR_OK) && (opnd_ext != optr_p1)) begin
            sticky_d = ERR_FORM;
          end
          ret_last_d = 1'b1;
          state_d    = S_LAST_LOOP;
        end
      end
      S_LAST_LOOP: begin
        if ((sticky_q == ERR_OK) && (optr_q != '0)) begin
          if (red_bad) begin
            sticky_d = ERR_FORM;
            state_d  = S_FINISH;
          end else begin
            state_d = S_RD_R;
          end
        end else begin
          state_d = S_LAST_CHK;
        end
      end
      S_LAST_CHK: begin
        // the read of the bottom entry is launched here
        if ((sticky_q == ERR_OK) && (opnd_q != CNT_W'(1))) begin
          sticky_d = ERR_FORM;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          opnd_d         = '0;
          optr_d         = '0;
          sticky_d       = ERR_OK;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      opnd_q      <= '0;
      optr_q      <= '0;
      sticky_q    <= ERR_OK;
      tok_q       <= '0;
      last_q      <= 1'b0;
      op_q        <= OP_ADD;
      ret_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      opnd_q      <= opnd_d;
      optr_q      <= optr_d;
      sticky_q    <= sticky_d;
      tok_q       <= tok_d;
      last_q      <= last_d;
      op_q        <= op_d;
      ret_last_q  <= ret_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Checks
  `IEE_ASSERT_IMP(a_opnd_bound, clk_i, rst_ni, 1'b1, opnd_q <= CNT_W'(STACK_DEPTH), "operand count beyond stack depth")
  `IEE_ASSERT_IMP(a_count_shape, clk_i, rst_ni, (state_q == S_IDLE) && (sticky_q == ERR_OK), (opnd_q == optr_q) || (opnd_ext == optr_p1), "operand and operator counts out of step")
  `IEE_ASSERT_IMP(a_reduce_operands, clk_i, rst_ni, state_q == S_RD_R, (opnd_q >= CNT_W'(2)) && (optr_q != '0), "reduction started without operands")
  `IEE_ASSERT_IMP(a_out_from_emit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_EMIT), "result raised outside emit")
  `IEE_ASSERT_NXT(a_wait_after_exec, clk_i, rst_ni, state_q == S_EXEC, (state_q == S_WAIT) && !cmd_o.arith_start, "arithmetic started twice")

endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an infix expression of single digits and + - x / sent one
// character per item, and reports value, target match and error code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, in_item_i) takes one character
//   per item; is_last marks the end of the expression. Output channel
//   (out_valid_o / out_ready_i, out_item_o) gives one result per expression.
//   cfg_we_i / cfg_wdata_i write the signed target value (reset 24); write
//   it only while the block is idle.
//   One item is worked on at a time. An operator first reduces each
//   stacked operator that binds at least as tight as itself, and a
//   divide waits for the bit-serial divider. The last item reduces every
//   remaining operator; the result is registered once the output
//   register is free. A reduction is paced by the single read port of
//   the operand stack (two reads, then the arithmetic unit).
//   A result waiting in the output register does not stop the next
//   expression: only a further result waits until the receiver takes it.
//   Reset clears the counts, error state and output valid; the target
//   returns to 24.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_expression_evaluator import iee_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [TARGET_WIDTH-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_item_t                in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_item_t               out_item_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  iee_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Stacks and arithmetic
  iee_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== sim/tb_infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Self-checking bench for the infix expression evaluator. Character items
// are fed over the input handshake, the expected value, target match and
// error code of every expression are worked out alongside, and each result
// leaving the output handshake is compared with them in order. A short
// directed set comes first, then random expressions under four target
// settings and three idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;
  import iee_pkg::*;

  localparam longint VAL_MAX      = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint VAL_MIN      = -VAL_MAX - 1;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     PHASE_ITEMS   = 270;
  localparam int     CYCLE_LIMIT   = 1000000;

  // Expression evaluator mirror plus the queue of results still owed
  class expr_scoreboard;
    longint                         opnd_stack[STACK_DEPTH];
    op_e                            optr_stack[STACK_DEPTH];
    int unsigned                    opnd_cnt = 0;
    int unsigned                    optr_cnt = 0;
    err_e                           sticky = ERR_OK;
    logic signed [TARGET_WIDTH-1:0] target = TARGET_RESET;
    out_item_t                      expected_q[$];
    int                             failures = 0;
    int                             results = 0;
    int                             hit_cnt = 0;
    int                             outcome_cnt[5] = '{default: 0};

    function bit binds_tight(op_e op);
      return (op == OP_MUL) || (op == OP_DIV);
    endfunction

    // One arithmetic step, range checked at VALUE_WIDTH bits
    function err_e combine(longint l, longint r, op_e op, output longint res);
      res = 0;
      case (op)
        OP_ADD: res = l + r;
        OP_SUB: res = l - r;
        OP_MUL: res = l * r;
        default: begin
          if (r == 0) return ERR_DIV0;
          res = l / r;
        end
      endcase
      if (res > VAL_MAX || res < VAL_MIN) return ERR_OVF;
      return ERR_OK;
    endfunction

    // Pop one operator and two operands, push the outcome
    function err_e fold_top();
      longint res;
      err_e   e;
      if (optr_cnt == 0 || opnd_cnt < 2) return ERR_FORM;
      e = combine(opnd_stack[opnd_cnt-2], opnd_stack[opnd_cnt-1],
                  optr_stack[optr_cnt-1], res);
      optr_cnt--;
      opnd_cnt -= 2;
      if (e != ERR_OK) return e;
      opnd_stack[opnd_cnt] = res;
      opnd_cnt++;
      return ERR_OK;
    endfunction

    function err_e take_char(logic [7:0] c);
      op_e  op;
      err_e e;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        if (opnd_cnt != optr_cnt || opnd_cnt >= STACK_DEPTH) return ERR_FORM;
        opnd_stack[opnd_cnt] = longint'(c - CHAR_ZERO);
        opnd_cnt++;
        return ERR_OK;
      end
      case (c)
        CHAR_PLUS:  op = OP_ADD;
        CHAR_MINUS: op = OP_SUB;
        CHAR_TIMES: op = OP_MUL;
        CHAR_SLASH: op = OP_DIV;
        default:    return ERR_CHAR;
      endcase
      if (opnd_cnt != optr_cnt + 1) return ERR_FORM;
      // left associative: equal rank folds too
      while (optr_cnt > 0 && (binds_tight(optr_stack[optr_cnt-1]) || !binds_tight(op))) begin
        e = fold_top();
        if (e != ERR_OK) return e;
      end
      if (optr_cnt >= STACK_DEPTH) return ERR_FORM;
      optr_stack[optr_cnt] = op;
      optr_cnt++;
      return ERR_OK;
    endfunction

    // Accepted input item; a last item closes the expression
    function void note_item(in_item_t it);
      out_item_t want;
      longint    val;
      if (sticky == ERR_OK) sticky = take_char(it.token_char);
      if (!it.is_last) return;
      if (sticky == ERR_OK && opnd_cnt != optr_cnt + 1) sticky = ERR_FORM;
      while (sticky == ERR_OK && optr_cnt > 0) sticky = fold_top();
      if (sticky == ERR_OK && opnd_cnt != 1) sticky = ERR_FORM;
      val = (sticky == ERR_OK) ? opnd_stack[0] : 0;
      want.value          = val[VALUE_WIDTH-1:0];
      want.matches_target = (sticky == ERR_OK) && (val == longint'(target));
      want.error_code     = sticky;
      expected_q.push_back(want);
      outcome_cnt[int'(sticky)]++;
      if (want.matches_target) hit_cnt++;
      opnd_cnt = 0;
      optr_cnt = 0;
      sticky   = ERR_OK;
    endfunction

    // Result leaving the block, checked against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (expected_q.size() == 0) begin
        if (failures < 10)
          $display("[%0t] unexpected result: value %0d match %0b err %0d",
                   $time, got.value, got.matches_target, got.error_code);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value || got.matches_target !== want.matches_target ||
          got.error_code !== want.error_code) begin
        if (failures < 10)
          $display("[%0t] mismatch: want value %0d match %0b err %0d, got %0d %0b %0d",
                   $time, want.value, want.matches_target, want.error_code,
                   got.value, got.matches_target, got.error_code);
        failures++;
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [TARGET_WIDTH-1:0] cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  in_item_t                in_item_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  out_item_t               out_item_o;

  expr_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int cycle_cnt     = 0;

  infix_expression_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else         out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  function automatic logic [7:0] pick_digit();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_TIMES;
      default: return CHAR_SLASH;
    endcase
  endfunction

  // Offer one item, holding valid until it is taken
  task automatic send_token(logic [7:0] c, logic last);
    int       gap;
    in_item_t it;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.token_char = c;
    it.is_last    = last;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_expr(string s);
    for (int i = 0; i < s.len(); i++) send_token(s[i], i == s.len() - 1);
  endtask

  // Well-formed expressions mostly; some broken ones and plain noise
  task automatic send_random_expr();
    logic [7:0] chars[$];
    int         kind;
    int         n_ops;
    int         spot;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(255)));
    end else begin
      n_ops = ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      chars.push_back(pick_digit());
      // long chains lean on multiply to reach overflow
      repeat (n_ops) begin
        if (n_ops >= 4 && $urandom_range(1) == 1) chars.push_back(CHAR_TIMES);
        else                                      chars.push_back(pick_op());
        chars.push_back(pick_digit());
      end
      if (kind < 20) begin
        spot = $urandom_range(chars.size() - 1);
        case ($urandom_range(2))
          0: chars[spot] = 8'($urandom_range(255));
          1: if (chars.size() > 1) chars.delete(spot);
             else chars.push_back(pick_digit());
          default: chars.push_back(pick_op());
        endcase
      end
    end
    foreach (chars[i]) send_token(chars[i], i == chars.size() - 1);
  endtask

  // Hold off until every result is in and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_target(logic signed [TARGET_WIDTH-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.target = v;
  endtask

  initial begin
    logic signed [TARGET_WIDTH-1:0] tgt;
    int                             mark;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset target, every operator, error kinds
    send_idle_pct = 38;
    recv_idle_pct = 82;
    send_expr("8x3");
    send_expr("7/0");
    send_expr("0-7/2+1");
    send_expr("9x9x9x9x9");
    send_expr("+");
    send_expr("12");
    send_expr("3-");
    send_expr("z");
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 82;
          tgt = TARGET_WIDTH'(VAL_MIN);
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 38;
          tgt = TARGET_WIDTH'(VAL_MAX);
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          tgt = TARGET_WIDTH'(int'($urandom_range(30)) - 5);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          tgt = '0;
        end
      endcase
      write_target(tgt);
      // value range edges and one step past them
      case (ph)
        0: begin
          send_expr("0-4x8x8x8x8-4x8x8x8x8");
          send_expr("0-4x8x8x8x8-4x8x8x8x8-1");
        end
        1: begin
          send_expr("4x8x8x8x8-1+4x8x8x8x8");
          send_expr("4x8x8x8x8-1+4x8x8x8x8+1");
        end
        default: ;
      endcase
      mark = items_sent;
      while (items_sent - mark < PHASE_ITEMS) begin
        send_random_expr();
        if ($urandom_range(49) == 0) settle();
      end
      settle();
    end

    $display("Ran %0d items forming %0d expressions, %0d matching the target",
             items_sent, sb.results, sb.hit_cnt);
    $display("Outcomes ok/char/form/div0/ovf: %0d/%0d/%0d/%0d/%0d",
             sb.outcome_cnt[ERR_OK], sb.outcome_cnt[ERR_CHAR], sb.outcome_cnt[ERR_FORM],
             sb.outcome_cnt[ERR_DIV0], sb.outcome_cnt[ERR_OVF]);
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
